>>> rtl/pcap_pkg.sv
// Package for the pcap IPv4 header extractor.
// Holds the parser phase and status codes, length constants and the shared structs.
// No dependencies.
package pcap_pkg;

  localparam int unsigned FILE_HDR_BYTES   = 24;
  localparam int unsigned REC_HDR_BYTES    = 16;
  localparam int unsigned PARSED_BYTES     = 34;
  localparam logic [15:0] MTU_RESET        = 16'd4000;

  localparam logic [4:0]  FILE_HDR_LAST    = 5'(FILE_HDR_BYTES - 1);
  localparam logic [3:0]  REC_HDR_LAST     = 4'(REC_HDR_BYTES - 1);
  localparam logic [16:0] PARSED_BYTES_W   = 17'(PARSED_BYTES);

  typedef enum logic [1:0] {
    PH_FILE,
    PH_RECHDR,
    PH_FRAME
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_OVER_MTU,
    ST_ACTUAL_SHORT,
    ST_FRAME_SHORT
  } status_t;

  typedef struct packed {
    logic       store;
    logic       clear;
    logic       emit;
    status_t    status;
    logic [5:0] pos;
  } ctrl_t;

  typedef struct packed {
    status_t     status;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ethertype;
    logic [5:0]  ip_header_bytes;
    logic [5:0]  dscp;
    logic [15:0] total_length;
    logic [15:0] identification;
    logic [15:0] flags_offset_word;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [63:0] ip_addresses;
  } result_t;

endpackage

>>> rtl/pcap_ipv4_header_extractor.sv
// Top level of the pcap IPv4 header extractor.
// Instantiates pcap_ctrl, pcap_fields and pcap_out_reg. Depends on pcap_pkg.
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_ready  | data_byte
//   result  | out       | out_valid / out_ready| status .. ip_addresses
//   config  | in        | cfg_wr_en            | cfg_wr_data (mtu_limit)
//
// One capture byte is taken every cycle while in_ready is high; a result is
// registered in the cycle after the byte that completes it and sits in the
// result register until taken. in_ready drops only while a result waits and
// out_ready is low. Synchronous reset restores the file header skip, clears
// the halt flag and sets mtu_limit to 4000; there is no clearing pass.
module pcap_ipv4_header_extractor import pcap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [47:0] dst_mac,
  output logic [47:0] src_mac,
  output logic [15:0] ethertype,
  output logic [5:0]  ip_header_bytes,
  output logic [5:0]  dscp,
  output logic [15:0] total_length,
  output logic [15:0] identification,
  output logic [15:0] flags_offset_word,
  output logic [7:0]  ttl,
  output logic [7:0]  protocol,
  output logic [63:0] ip_addresses
);

  ctrl_t   ctrl;
  result_t result;
  result_t held;
  logic    fire;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  pcap_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .data_byte   (data_byte),
    .ctrl        (ctrl)
  );

  pcap_fields u_fields (
    .clk       (clk),
    .ctrl      (ctrl),
    .data_byte (data_byte),
    .result    (result)
  );

  pcap_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (ctrl.emit),
    .result    (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .held      (held)
  );

  assign status            = held.status;
  assign dst_mac           = held.dst_mac;
  assign src_mac           = held.src_mac;
  assign ethertype         = held.ethertype;
  assign ip_header_bytes   = held.ip_header_bytes;
  assign dscp              = held.dscp;
  assign total_length      = held.total_length;
  assign identification    = held.identification;
  assign flags_offset_word = held.flags_offset_word;
  assign ttl               = held.ttl;
  assign protocol          = held.protocol;
  assign ip_addresses      = held.ip_addresses;

endmodule

>>> rtl/pcap_ctrl.sv
// Stream sequencer: file header skip, record header decode, frame byte counting.
// Holds the MTU register and the halt flag. Depends on pcap_pkg.
module pcap_ctrl import pcap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        fire,
  input  logic [7:0]  data_byte,
  output ctrl_t       ctrl
);

  phase_t      phase, phase_next;
  logic [15:0] byte_index, byte_index_next;
  logic [15:0] record_length, record_length_next;
  logic [31:0] cap_len, cap_len_next;
  logic [23:0] act_acc, act_acc_next;
  logic        halted, halted_next;
  logic [15:0] mtu_limit;
  logic [31:0] actual_len;
  logic [3:0]  hdr_pos;

  assign hdr_pos    = byte_index[3:0];
  assign actual_len = {data_byte, act_acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      mtu_limit <= MTU_RESET;
    end else if (cfg_wr_en) begin
      mtu_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FILE;
      byte_index    <= '0;
      record_length <= '0;
      halted        <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      record_length <= record_length_next;
      halted        <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    cap_len <= cap_len_next;
    act_acc <= act_acc_next;
  end

  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    record_length_next = record_length;
    cap_len_next       = cap_len;
    act_acc_next       = act_acc;
    halted_next        = halted;
    ctrl               = '0;
    ctrl.status        = ST_OK;
    ctrl.pos           = byte_index[5:0];
    if (fire && !halted) begin
      unique case (phase)
        PH_FILE: begin
          if (byte_index[4:0] == FILE_HDR_LAST) begin
            phase_next      = PH_RECHDR;
            byte_index_next = '0;
          end else begin
            byte_index_next = byte_index + 16'd1;
          end
        end
        PH_RECHDR: begin
          if (hdr_pos >= 4'd8 && hdr_pos < 4'd12) begin
            cap_len_next[8*hdr_pos[1:0] +: 8] = data_byte;
          end else if (hdr_pos >= 4'd12 && hdr_pos != REC_HDR_LAST) begin
            act_acc_next[8*hdr_pos[1:0] +: 8] = data_byte;
          end
          if (hdr_pos == REC_HDR_LAST) begin
            byte_index_next = '0;
            ctrl.clear      = 1'b1;
            priority if (actual_len > {16'd0, mtu_limit}) begin
              halted_next = 1'b1;
              ctrl.emit   = 1'b1;
              ctrl.status = ST_OVER_MTU;
            end else if (actual_len < cap_len) begin
              halted_next = 1'b1;
              ctrl.emit   = 1'b1;
              ctrl.status = ST_ACTUAL_SHORT;
            end else if (cap_len[15:0] == 16'd0) begin
              record_length_next = '0;
              ctrl.emit          = 1'b1;
              ctrl.status        = ST_FRAME_SHORT;
            end else begin
              record_length_next = cap_len[15:0];
              phase_next         = PH_FRAME;
            end
          end else begin
            byte_index_next = {12'd0, hdr_pos + 4'd1};
          end
        end
        PH_FRAME: begin
          ctrl.store      = ({1'b0, byte_index} < PARSED_BYTES_W);
          byte_index_next = byte_index + 16'd1;
          if ({1'b0, byte_index} + 17'd1 >= {1'b0, record_length}) begin
            phase_next      = PH_RECHDR;
            byte_index_next = '0;
            ctrl.emit       = 1'b1;
            ctrl.status     = ({1'b0, record_length} < PARSED_BYTES_W) ? ST_FRAME_SHORT
                                                                        : ST_OK;
          end
        end
        default: begin
          phase_next = PH_FILE;
        end
      endcase
    end
  end

endmodule

>>> rtl/pcap_fields.sv
// Frame header byte store and field extraction for one result.
// Driven by the control struct from pcap_ctrl. Depends on pcap_pkg.
module pcap_fields import pcap_pkg::*; (
  input  logic       clk,
  input  ctrl_t      ctrl,
  input  logic [7:0] data_byte,
  output result_t    result
);

  logic [7:0] hdr     [PARSED_BYTES];
  logic [7:0] hdr_now [PARSED_BYTES];

  always_comb begin
    for (int k = 0; k < PARSED_BYTES; k++) begin
      if (ctrl.clear) begin
        hdr_now[k] = '0;
      end else if (ctrl.store && ctrl.pos == 6'(k)) begin
        hdr_now[k] = data_byte;
      end else begin
        hdr_now[k] = hdr[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PARSED_BYTES; k++) begin
      hdr[k] <= hdr_now[k];
    end
  end

  always_comb begin
    result.status            = ctrl.status;
    result.dst_mac           = {hdr_now[0], hdr_now[1], hdr_now[2],
                                hdr_now[3], hdr_now[4], hdr_now[5]};
    result.src_mac           = {hdr_now[6], hdr_now[7], hdr_now[8],
                                hdr_now[9], hdr_now[10], hdr_now[11]};
    result.ethertype         = {hdr_now[12], hdr_now[13]};
    result.ip_header_bytes   = {hdr_now[14][3:0], 2'b00};
    result.dscp              = hdr_now[15][7:2];
    result.total_length      = {hdr_now[16], hdr_now[17]};
    result.identification    = {hdr_now[18], hdr_now[19]};
    result.flags_offset_word = {hdr_now[20], hdr_now[21]};
    result.ttl               = hdr_now[22];
    result.protocol          = hdr_now[23];
    result.ip_addresses      = {hdr_now[26], hdr_now[27], hdr_now[28], hdr_now[29],
                                hdr_now[30], hdr_now[31], hdr_now[32], hdr_now[33]};
  end

endmodule

>>> rtl/pcap_out_reg.sv
// Result register with valid and ready toward the consumer.
// Depends on pcap_pkg for the result struct.
module pcap_out_reg import pcap_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

>>> rtl/pcap_checker.sv
// Port-level checker for the pcap IPv4 header extractor, with its bind.
// Depends on pcap_pkg for the status codes.
module pcap_checker import pcap_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [47:0] dst_mac,
  input logic [5:0]  ip_header_bytes,
  input logic [63:0] ip_addresses
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid after reset.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input stalled with an empty result register.");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(dst_mac))
    else $error("Stalled result changed.");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OVER_MTU || status == ST_ACTUAL_SHORT)
      |-> dst_mac == '0 && ip_addresses == '0 && ip_header_bytes == '0)
    else $error("Length error result carries frame fields.");

endmodule

bind pcap_ipv4_header_extractor pcap_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .status          (status),
  .dst_mac         (dst_mac),
  .ip_header_bytes (ip_header_bytes),
  .ip_addresses    (ip_addresses)
);

>>> tb/sv/pcap_ipv4_header_extractor_test.sv
// Self-checking testbench for pcap_ipv4_header_extractor: builds capture streams, predicts each
// record result and checks it. Depends on pcap_pkg and the pcap_ipv4_header_extractor RTL.
`timescale 1ns / 1ps

module pcap_ipv4_header_extractor_test;
  import pcap_pkg::*;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [47:0] dst_mac;
  logic [47:0] src_mac;
  logic [15:0] ethertype;
  logic [5:0]  ip_header_bytes;
  logic [5:0]  dscp;
  logic [15:0] total_length;
  logic [15:0] identification;
  logic [15:0] flags_offset_word;
  logic [7:0]  ttl;
  logic [7:0]  protocol;
  logic [63:0] ip_addresses;

  pcap_ipv4_header_extractor dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .dst_mac(dst_mac),
    .src_mac(src_mac),
    .ethertype(ethertype),
    .ip_header_bytes(ip_header_bytes),
    .dscp(dscp),
    .total_length(total_length),
    .identification(identification),
    .flags_offset_word(flags_offset_word),
    .ttl(ttl),
    .protocol(protocol),
    .ip_addresses(ip_addresses)
  );

  logic [7:0]  capture_bytes[$];
  result_t     expected_records[$];
  int unsigned bytes_queued = 0;
  int unsigned records_queued = 0;
  bit          steady = 1'b0;
  bit          mismatch_seen = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  result_t     want_record;

  // Shadow of the parser state.
  logic [15:0] mtu_shadow = MTU_RESET;
  phase_t      prs_phase = PH_FILE;
  logic [15:0] prs_index = '0;
  logic [15:0] frame_len = '0;
  logic [31:0] capt_len = '0;
  logic [31:0] actual_len = '0;
  result_t     building = '0;
  bit          halted = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic emit_record(input status_t s);
    building.status = s;
    expected_records.insert(expected_records.size(), building);
  endtask

  task automatic parse_capture_byte(input logic [7:0] b);
    int unsigned i;
    if (halted) return;
    case (prs_phase)
      PH_FILE: begin
        prs_index = prs_index + 16'd1;
        if (prs_index >= FILE_HDR_BYTES) begin
          prs_phase = PH_RECHDR;
          prs_index = '0;
        end
      end
      PH_RECHDR: begin
        i = 32'(prs_index[3:0]);
        if (i == 0) begin
          capt_len = '0;
          actual_len = '0;
        end
        if (i >= 8 && i < 12) capt_len[8*(i-8) +: 8] = b;
        else if (i >= 12) actual_len[8*(i-12) +: 8] = b;
        prs_index = 16'(i + 1);
        if (prs_index == REC_HDR_BYTES) begin
          prs_index = '0;
          building = '0;
          if (actual_len > 32'(mtu_shadow)) begin
            halted = 1'b1;
            emit_record(ST_OVER_MTU);
          end else if (actual_len < capt_len) begin
            halted = 1'b1;
            emit_record(ST_ACTUAL_SHORT);
          end else begin
            frame_len = capt_len[15:0];
            if (frame_len == 0) emit_record(ST_FRAME_SHORT);
            else prs_phase = PH_FRAME;
          end
        end
      end
      default: begin
        i = 32'(prs_index);
        if (i < 6) building.dst_mac[8*(5-i) +: 8] = b;
        else if (i < 12) building.src_mac[8*(11-i) +: 8] = b;
        else if (i < 14) building.ethertype[8*(13-i) +: 8] = b;
        else if (i == 14) building.ip_header_bytes = {b[3:0], 2'b00};
        else if (i == 15) building.dscp = b[7:2];
        else if (i < 18) building.total_length[8*(17-i) +: 8] = b;
        else if (i < 20) building.identification[8*(19-i) +: 8] = b;
        else if (i < 22) building.flags_offset_word[8*(21-i) +: 8] = b;
        else if (i == 22) building.ttl = b;
        else if (i == 23) building.protocol = b;
        else if (i >= 26 && i < PARSED_BYTES) building.ip_addresses[8*(33-i) +: 8] = b;
        prs_index = prs_index + 16'd1;
        if (i + 1 >= 32'(frame_len)) begin
          prs_phase = PH_RECHDR;
          prs_index = '0;
          if (frame_len < PARSED_BYTES) emit_record(ST_FRAME_SHORT);
          else emit_record(ST_OK);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parse_capture_byte(data_byte);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (capture_bytes.size() != 0) begin
          data_byte <= capture_bytes.pop_front();
          in_valid <= 1'b1;
          send_gap = draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_seen = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        $display("%0t: result with none expected, status %0d", $time, status);
        mismatch_seen = 1'b1;
      end else begin
        want_record = expected_records.pop_front();
        check_field("status", 64'(want_record.status), 64'(status));
        check_field("dst_mac", 64'(want_record.dst_mac), 64'(dst_mac));
        check_field("src_mac", 64'(want_record.src_mac), 64'(src_mac));
        check_field("ethertype", 64'(want_record.ethertype), 64'(ethertype));
        check_field("ip_header_bytes", 64'(want_record.ip_header_bytes),
                    64'(ip_header_bytes));
        check_field("dscp", 64'(want_record.dscp), 64'(dscp));
        check_field("total_length", 64'(want_record.total_length), 64'(total_length));
        check_field("identification", 64'(want_record.identification),
                    64'(identification));
        check_field("flags_offset_word", 64'(want_record.flags_offset_word),
                    64'(flags_offset_word));
        check_field("ttl", 64'(want_record.ttl), 64'(ttl));
        check_field("protocol", 64'(want_record.protocol), 64'(protocol));
        check_field("ip_addresses", want_record.ip_addresses, ip_addresses);
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = draw_gap();
    end
  end

  task automatic push_byte(input logic [7:0] b);
    capture_bytes.insert(capture_bytes.size(), b);
    bytes_queued++;
  endtask

  task automatic push_record(input logic [31:0] capt, input logic [31:0] actual,
                             input fill_t fill);
    for (int k = 0; k < 8; k++) push_byte(8'($urandom));
    for (int k = 0; k < 4; k++) push_byte(capt[8*k +: 8]);
    for (int k = 0; k < 4; k++) push_byte(actual[8*k +: 8]);
    records_queued++;
    if (actual <= 32'(mtu_shadow) && capt <= actual) begin
      for (int k = 0; k < capt; k++) begin
        case (fill)
          FILL_ZERO: push_byte(8'h00);
          FILL_ONES: push_byte(8'hFF);
          default:   push_byte(8'($urandom));
        endcase
      end
    end
  endtask

  task automatic push_random_records(input int unsigned min_bytes, input int unsigned min_records);
    int unsigned start_bytes;
    int unsigned start_records;
    int unsigned r;
    logic [31:0] capt;
    logic [31:0] actual;
    start_bytes = bytes_queued;
    start_records = records_queued;
    while (bytes_queued - start_bytes < min_bytes ||
           records_queued - start_records < min_records) begin
      r = $urandom_range(0, 99);
      if (r < 70) capt = $urandom_range(0, 70);
      else if (r < 95) capt = $urandom_range(0, 33);
      else capt = $urandom_range(100, 400);
      if (capt > 32'(mtu_shadow)) capt = 32'(mtu_shadow);
      r = $urandom_range(0, 2);
      if (r == 0) actual = capt;
      else if (r == 1) actual = 32'(mtu_shadow);
      else actual = $urandom_range(capt, mtu_shadow);
      push_record(capt, actual, FILL_RANDOM);
    end
  endtask

  task automatic wait_drained();
    while (capture_bytes.size() != 0 || in_valid || expected_records.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mtu(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    mtu_shadow = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [31:0] err_capt;
    logic [31:0] err_actual;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset MTU: short frames, empty frames, exact MTU and boundary lengths.
    for (int k = 0; k < FILE_HDR_BYTES; k++) push_byte(8'($urandom));
    push_record(0, 0, FILL_RANDOM);
    push_record(0, 500, FILL_RANDOM);
    push_record(1, 1, FILL_ONES);
    push_record(13, 20, FILL_RANDOM);
    push_record(25, 25, FILL_RANDOM);
    push_record(33, 60, FILL_RANDOM);
    push_record(34, 34, FILL_ONES);
    push_record(34, 4000, FILL_ZERO);
    push_record(35, 1500, FILL_RANDOM);
    push_record(60, 60, FILL_RANDOM);
    wait_drained();

    steady = $urandom_range(0, 3) == 0;
    write_mtu(16'hFFFF);
    push_record(40, 65535, FILL_ONES);
    push_random_records(350, 6);
    wait_drained();

    // With a zero MTU only empty records pass.
    steady = 1'b0;
    write_mtu(16'h0000);
    push_record(0, 0, FILL_RANDOM);
    push_record(0, 0, FILL_RANDOM);
    wait_drained();

    steady = $urandom_range(0, 3) == 0;
    write_mtu(16'($urandom_range(34, 4000)));
    push_random_records(350, 6);
    wait_drained();

    steady = 1'b1;
    write_mtu(16'd34);
    push_random_records(220, 5);
    wait_drained();

    // A length error halts the parser for the rest of the run.
    steady = 1'b0;
    write_mtu(16'($urandom_range(0, 65535)));
    push_random_records(100, 3);
    if ($urandom_range(0, 1) == 0) begin
      err_actual = 32'(mtu_shadow) + 1 + $urandom_range(0, 1000);
      if ($urandom_range(0, 1) == 0)
        err_actual[31:16] = err_actual[31:16] | 16'($urandom) | 16'h1;
      err_capt = $urandom_range(0, 60);
    end else begin
      err_actual = $urandom_range(0, mtu_shadow);
      if ($urandom_range(0, 1) == 0) err_capt = err_actual + 1 + $urandom_range(0, 50);
      else err_capt = $urandom | 32'h0001_0000;
    end
    push_record(err_capt, err_actual, FILL_RANDOM);
    for (int k = 0; k < 40; k++) push_byte(8'($urandom));
    wait_drained();
    repeat (16) @(posedge clk);

    if (!mismatch_seen && expected_records.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
